[hdl/dss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the decimal string splitter: byte classes,
// the token that travels from the front part to the back part, status codes.
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int MAX_CHARS = 64;
    localparam int CNT_W     = $clog2(MAX_CHARS);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CHARS - 1);

    localparam int MANT_W = 64;
    localparam int EXP_W  = 32;
    localparam int MANT_PROD_W = MANT_W + 4;
    localparam int EXP_PROD_W  = EXP_W + 4;
    localparam int EXP_SUM_W   = EXP_W + 2;

    localparam logic [MANT_PROD_W-1:0] MANT_LIMIT = MANT_PROD_W'(1) << (MANT_W - 1);
    localparam logic [EXP_PROD_W-1:0]  EXP_LIMIT  = EXP_PROD_W'(1) << (EXP_W - 1);
    localparam logic [MANT_W-1:0]      MANT_MAX   = MANT_W'(1) << (MANT_W - 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_E_LOW  = 8'h65;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SYNTAX   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef enum logic [2:0] {
        K_END,
        K_DIGIT,
        K_PLUS,
        K_MINUS,
        K_POINT,
        K_LETTER,
        K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
    } t_token;

endpackage

[hdl/dss_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_front
// Byte classifier: turns each text byte into a kind and a digit value.
// ----------------------------------------------------------------------------
module dss_front (
    input  logic [7:0]      i_char,
    output dss_pkg::t_token o_tok
);

    logic [7:0] w_off;

    assign w_off = i_char - dss_pkg::CH_ZERO;

    always_comb begin
        o_tok.digit = w_off[3:0];
        if (i_char == dss_pkg::CH_NUL) begin
            o_tok.kind = dss_pkg::K_END;
        end else if (i_char >= dss_pkg::CH_ZERO && i_char <= dss_pkg::CH_NINE) begin
            o_tok.kind = dss_pkg::K_DIGIT;
        end else if (i_char == dss_pkg::CH_PLUS) begin
            o_tok.kind = dss_pkg::K_PLUS;
        end else if (i_char == dss_pkg::CH_MINUS) begin
            o_tok.kind = dss_pkg::K_MINUS;
        end else if (i_char == dss_pkg::CH_POINT) begin
            o_tok.kind = dss_pkg::K_POINT;
        end else if (i_char == dss_pkg::CH_E_UP || i_char == dss_pkg::CH_E_LOW) begin
            o_tok.kind = dss_pkg::K_LETTER;
        end else begin
            o_tok.kind = dss_pkg::K_OTHER;
        end
    end

endmodule

[hdl/dss_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_queue
// Two-entry token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module dss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  dss_pkg::t_token i_push_tok,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output dss_pkg::t_token o_pop_tok
);

    dss_pkg::t_token r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_tok    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[hdl/dss_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_back
// Parser: runs the number grammar on tokens, accumulates mantissa and
// exponent, and registers one result per terminated string.
// ----------------------------------------------------------------------------
module dss_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok_valid,
    output logic                          o_tok_ready,
    input  dss_pkg::t_token               i_tok,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [1:0]                    o_res_status,
    output logic [dss_pkg::MANT_W-1:0]    o_res_mant,
    output logic [dss_pkg::EXP_W-1:0]     o_res_exp
);

    typedef enum logic [2:0] {
        PH_START,
        PH_BASE,
        PH_FRACTION,
        PH_EXP,
        PH_ERROR
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [dss_pkg::MANT_W-1:0]      r_mant_acc, n_mant_acc;
    logic                            r_mant_neg, n_mant_neg;
    logic                            r_mant_seen, n_mant_seen;
    logic [dss_pkg::EXP_W-1:0]       r_exp_acc, n_exp_acc;
    logic                            r_exp_neg, n_exp_neg;
    logic                            r_exp_seen, n_exp_seen;
    logic                            r_exp_closed, n_exp_closed;
    logic [dss_pkg::CNT_W-1:0]       r_frac_cnt, n_frac_cnt;
    logic [dss_pkg::CNT_W-1:0]       r_char_cnt, n_char_cnt;
    logic [1:0]                      r_err_code, n_err_code;
    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_out_status, n_out_status;
    logic [dss_pkg::MANT_W-1:0]      r_out_mant, n_out_mant;
    logic [dss_pkg::EXP_W-1:0]       r_out_exp, n_out_exp;

    logic [dss_pkg::MANT_PROD_W-1:0] w_mant_ext;
    logic [dss_pkg::MANT_PROD_W-1:0] w_mant_next;
    logic [dss_pkg::EXP_PROD_W-1:0]  w_exp_ext;
    logic [dss_pkg::EXP_PROD_W-1:0]  w_exp_next;
    logic signed [dss_pkg::EXP_SUM_W-1:0] w_exp_mag;
    logic signed [dss_pkg::EXP_SUM_W-1:0] w_exp_final;
    logic                            w_exp_oor;
    logic [1:0]                      w_fin_status;
    logic [dss_pkg::MANT_W-1:0]      w_fin_mant;
    logic [dss_pkg::EXP_W-1:0]       w_fin_exp;
    logic                            w_pop;

    // times ten plus digit
    assign w_mant_ext  = dss_pkg::MANT_PROD_W'(r_mant_acc);
    assign w_mant_next = (w_mant_ext << 3) + (w_mant_ext << 1)
                         + dss_pkg::MANT_PROD_W'(i_tok.digit);
    assign w_exp_ext   = dss_pkg::EXP_PROD_W'(r_exp_acc);
    assign w_exp_next  = (w_exp_ext << 3) + (w_exp_ext << 1)
                         + dss_pkg::EXP_PROD_W'(i_tok.digit);

    // final exponent and its range
    assign w_exp_mag   = $signed(dss_pkg::EXP_SUM_W'(r_exp_acc));
    assign w_exp_final = (r_exp_neg ? -w_exp_mag : w_exp_mag)
                         - $signed(dss_pkg::EXP_SUM_W'(r_frac_cnt));
    assign w_exp_oor   = (w_exp_final[dss_pkg::EXP_SUM_W-1:dss_pkg::EXP_W-1] != 3'b000) &&
                         (w_exp_final[dss_pkg::EXP_SUM_W-1:dss_pkg::EXP_W-1] != 3'b111);

    always_comb begin
        w_fin_status = dss_pkg::ST_OK;
        w_fin_mant   = '0;
        w_fin_exp    = '0;
        if (r_phase == PH_ERROR) begin
            w_fin_status = r_err_code;
        end else if (r_phase == PH_START || !r_mant_seen ||
                     (r_phase == PH_EXP && !r_exp_seen)) begin
            w_fin_status = dss_pkg::ST_SYNTAX;
        end else if (!r_mant_neg && r_mant_acc == dss_pkg::MANT_MAX) begin
            w_fin_status = dss_pkg::ST_RANGE;
        end else if (w_exp_oor) begin
            w_fin_status = dss_pkg::ST_RANGE;
        end else begin
            w_fin_mant = r_mant_neg ? (~r_mant_acc + 1'b1) : r_mant_acc;
            w_fin_exp  = w_exp_final[dss_pkg::EXP_W-1:0];
        end
    end

    assign o_tok_ready = (i_tok.kind != dss_pkg::K_END) || !r_out_valid || i_res_ready;
    assign w_pop       = i_tok_valid && o_tok_ready;

    always_comb begin
        n_phase      = r_phase;
        n_mant_acc   = r_mant_acc;
        n_mant_neg   = r_mant_neg;
        n_mant_seen  = r_mant_seen;
        n_exp_acc    = r_exp_acc;
        n_exp_neg    = r_exp_neg;
        n_exp_seen   = r_exp_seen;
        n_exp_closed = r_exp_closed;
        n_frac_cnt   = r_frac_cnt;
        n_char_cnt   = r_char_cnt;
        n_err_code   = r_err_code;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_status = r_out_status;
        n_out_mant   = r_out_mant;
        n_out_exp    = r_out_exp;

        if (w_pop) begin
            if (i_tok.kind == dss_pkg::K_END) begin
                n_out_valid  = 1'b1;
                n_out_status = w_fin_status;
                n_out_mant   = w_fin_mant;
                n_out_exp    = w_fin_exp;
                n_phase      = PH_START;
                n_mant_acc   = '0;
                n_mant_neg   = 1'b0;
                n_mant_seen  = 1'b0;
                n_exp_acc    = '0;
                n_exp_neg    = 1'b0;
                n_exp_seen   = 1'b0;
                n_exp_closed = 1'b0;
                n_frac_cnt   = '0;
                n_char_cnt   = '0;
                n_err_code   = dss_pkg::ST_OK;
            end else if (r_phase != PH_ERROR) begin
                if (r_char_cnt >= dss_pkg::CNT_LIMIT) begin
                    n_phase    = PH_ERROR;
                    n_err_code = dss_pkg::ST_TOO_LONG;
                end else begin
                    n_char_cnt = r_char_cnt + 1'b1;
                    case (i_tok.kind)
                        dss_pkg::K_PLUS, dss_pkg::K_MINUS: begin
                            if (r_phase == PH_START) begin
                                n_mant_neg = (i_tok.kind == dss_pkg::K_MINUS);
                                n_phase    = PH_BASE;
                            end else if (r_phase == PH_EXP && !r_exp_closed) begin
                                n_exp_neg    = (i_tok.kind == dss_pkg::K_MINUS);
                                n_exp_closed = 1'b1;
                            end else begin
                                n_phase    = PH_ERROR;
                                n_err_code = dss_pkg::ST_SYNTAX;
                            end
                        end
                        dss_pkg::K_DIGIT: begin
                            if (r_phase == PH_EXP) begin
                                if (w_exp_next > dss_pkg::EXP_LIMIT) begin
                                    n_phase    = PH_ERROR;
                                    n_err_code = dss_pkg::ST_RANGE;
                                end else begin
                                    n_exp_acc    = w_exp_next[dss_pkg::EXP_W-1:0];
                                    n_exp_seen   = 1'b1;
                                    n_exp_closed = 1'b1;
                                end
                            end else if (w_mant_next > dss_pkg::MANT_LIMIT) begin
                                n_phase    = PH_ERROR;
                                n_err_code = dss_pkg::ST_RANGE;
                            end else begin
                                n_mant_acc  = w_mant_next[dss_pkg::MANT_W-1:0];
                                n_mant_seen = 1'b1;
                                if (r_phase == PH_START) begin
                                    n_phase = PH_BASE;
                                end else if (r_phase == PH_FRACTION) begin
                                    n_frac_cnt = r_frac_cnt + 1'b1;
                                end
                            end
                        end
                        dss_pkg::K_POINT: begin
                            if (r_phase == PH_START || r_phase == PH_BASE) begin
                                n_phase = PH_FRACTION;
                            end else begin
                                n_phase    = PH_ERROR;
                                n_err_code = dss_pkg::ST_SYNTAX;
                            end
                        end
                        dss_pkg::K_LETTER: begin
                            if (r_phase == PH_FRACTION) begin
                                n_phase = PH_EXP;
                            end else begin
                                n_phase    = PH_ERROR;
                                n_err_code = dss_pkg::ST_SYNTAX;
                            end
                        end
                        default: begin
                            n_phase    = PH_ERROR;
                            n_err_code = dss_pkg::ST_SYNTAX;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_mant_acc   <= '0;
            r_mant_neg   <= 1'b0;
            r_mant_seen  <= 1'b0;
            r_exp_acc    <= '0;
            r_exp_neg    <= 1'b0;
            r_exp_seen   <= 1'b0;
            r_exp_closed <= 1'b0;
            r_frac_cnt   <= '0;
            r_char_cnt   <= '0;
            r_err_code   <= dss_pkg::ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_mant_acc   <= n_mant_acc;
            r_mant_neg   <= n_mant_neg;
            r_mant_seen  <= n_mant_seen;
            r_exp_acc    <= n_exp_acc;
            r_exp_neg    <= n_exp_neg;
            r_exp_seen   <= n_exp_seen;
            r_exp_closed <= n_exp_closed;
            r_frac_cnt   <= n_frac_cnt;
            r_char_cnt   <= n_char_cnt;
            r_err_code   <= n_err_code;
            r_out_valid  <= n_out_valid;
        end
        r_out_status <= n_out_status;
        r_out_mant   <= n_out_mant;
        r_out_exp    <= n_out_exp;
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_status = r_out_status;
    assign o_res_mant   = r_out_mant;
    assign o_res_exp    = r_out_exp;

endmodule

[hdl/decimal_string_splitter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_splitter
// Parses a decimal number text, one byte per item, into a signed mantissa
// with the point removed and a power-of-ten exponent.
//
// Input channel (s_axis): one text byte per item; a zero byte ends a string.
// Output channel (m_axis): one item per string, status in tuser, mantissa
// and exponent in tdata; mantissa and exponent are zero when status is
// not ok.
// Throughput: one byte per cycle while the receiver takes results. A byte
// waits in a two-entry queue, and the parser takes one token per cycle
// (multiply by ten and add). The parser registers the result once it takes
// the terminator from the queue, behind any older tokens still waiting there.
// When the receiver stalls, the result stays in the output register; bytes
// of the next string keep flowing into the parser, and only a further
// terminator waits, after which the queue fills and tready falls.
// Reset (synchronous, active low) empties the queue and the output register
// and returns the parser to the start of a string.
// ----------------------------------------------------------------------------
module decimal_string_splitter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // char_code
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,   // mantissa [63:0], exponent [95:64]
    output logic [1:0]   o_m_axis_tuser    // status
);

    dss_pkg::t_token                w_front_tok;
    dss_pkg::t_token                w_queue_tok;
    logic                           w_queue_valid;
    logic                           w_back_ready;
    logic [dss_pkg::MANT_W-1:0]     w_mant;
    logic [dss_pkg::EXP_W-1:0]      w_exp;

    dss_front u_front (
        .i_char (i_s_axis_tdata),
        .o_tok  (w_front_tok)
    );

    dss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_s_axis_tvalid),
        .o_push_ready (o_s_axis_tready),
        .i_push_tok   (w_front_tok),
        .o_pop_valid  (w_queue_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_tok    (w_queue_tok)
    );

    dss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (w_queue_valid),
        .o_tok_ready  (w_back_ready),
        .i_tok        (w_queue_tok),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_status (o_m_axis_tuser),
        .o_res_mant   (w_mant),
        .o_res_exp    (w_exp)
    );

    assign o_m_axis_tdata = {w_exp, w_mant};

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the decimal string splitter. A queue of text bytes feeds
// a bursty driver; every byte the block takes is run through a bit-exact
// parser here, and each zero byte queues the status, mantissa and exponent
// the block must return. A monitor with its own stall pattern checks every
// returned item field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          RANDOM_BYTES = 1430;
    localparam logic [63:0] MANT_CAP     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_CAP      = 64'h0000_0000_8000_0000;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_BASE,
        SCAN_FRACTION,
        SCAN_EXP,
        SCAN_ERROR
    } t_scan_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       hold;
    } t_text_byte;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] mantissa;
        logic [31:0] exponent;
    } t_split_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;     // char_code
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [95:0] o_m_axis_tdata;            // mantissa [63:0], exponent [95:64]
    logic [1:0]  o_m_axis_tuser;            // status

    decimal_string_splitter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_text_byte    text_q[$];
    logic [7:0]    draft[$];
    t_split_result split_q[$];

    t_scan_phase   scan_phase;
    logic [63:0]   mant_mag;
    logic          mant_neg;
    logic          mant_seen;
    logic [63:0]   exp_mag;
    logic          exp_neg;
    logic          exp_seen;
    logic          exp_closed;
    int unsigned   frac_count;
    int unsigned   char_count;
    logic [1:0]    first_error;

    int            fail_count = 0;
    int            cycle_count = 0;
    int            strings_made = 0;
    int            bytes_taken = 0;
    int            status_seen[4] = '{0, 0, 0, 0};
    logic          in_taken = 1'b0;
    int            burst_left = 1;
    int            gap_left = 0;
    int            rx_mode = 0;
    int            rx_count = 0;

    // ---------------- parser mirror ----------------

    task automatic clear_split();
        scan_phase  = SCAN_START;
        mant_mag    = 64'd0;
        mant_neg    = 1'b0;
        mant_seen   = 1'b0;
        exp_mag     = 64'd0;
        exp_neg     = 1'b0;
        exp_seen    = 1'b0;
        exp_closed  = 1'b0;
        frac_count  = 0;
        char_count  = 0;
        first_error = dss_pkg::ST_OK;
    endtask

    task automatic raise_error(input logic [1:0] code);
        if (scan_phase != SCAN_ERROR) begin
            first_error = code;
            scan_phase  = SCAN_ERROR;
        end
    endtask

    task automatic split_char(input logic [7:0] c);
        logic [63:0]        d;
        logic signed [63:0] e;
        t_split_result      r;
        r.status   = dss_pkg::ST_OK;
        r.mantissa = 64'd0;
        r.exponent = 32'd0;
        if (c == dss_pkg::CH_NUL) begin
            if (scan_phase == SCAN_ERROR) begin
                r.status = first_error;
            end else if (scan_phase == SCAN_START || !mant_seen ||
                         (scan_phase == SCAN_EXP && !exp_seen)) begin
                r.status = dss_pkg::ST_SYNTAX;
            end else if (!mant_neg && mant_mag == MANT_CAP) begin
                r.status = dss_pkg::ST_RANGE;
            end else begin
                e = exp_neg ? -$signed(exp_mag) : $signed(exp_mag);
                e = e - $signed({32'd0, frac_count});
                if (e < -64'sh8000_0000 || e > 64'sh7FFF_FFFF) begin
                    r.status = dss_pkg::ST_RANGE;
                end else begin
                    r.mantissa = mant_neg ? (64'd0 - mant_mag) : mant_mag;
                    r.exponent = e[31:0];
                end
            end
            split_q.push_back(r);
            clear_split();
        end else if (scan_phase != SCAN_ERROR) begin
            if (char_count >= dss_pkg::MAX_CHARS - 1) begin
                raise_error(dss_pkg::ST_TOO_LONG);
            end else begin
                char_count++;
                if (c == dss_pkg::CH_MINUS || c == dss_pkg::CH_PLUS) begin
                    if (scan_phase == SCAN_START) begin
                        mant_neg   = (c == dss_pkg::CH_MINUS);
                        scan_phase = SCAN_BASE;
                    end else if (scan_phase == SCAN_EXP && !exp_closed) begin
                        exp_neg    = (c == dss_pkg::CH_MINUS);
                        exp_closed = 1'b1;
                    end else begin
                        raise_error(dss_pkg::ST_SYNTAX);
                    end
                end else if (c >= dss_pkg::CH_ZERO && c <= dss_pkg::CH_NINE) begin
                    d = {56'd0, c - dss_pkg::CH_ZERO};
                    if (scan_phase == SCAN_EXP) begin
                        if (exp_mag > (EXP_CAP - d) / 64'd10) begin
                            raise_error(dss_pkg::ST_RANGE);
                        end else begin
                            exp_mag    = exp_mag * 64'd10 + d;
                            exp_seen   = 1'b1;
                            exp_closed = 1'b1;
                        end
                    end else if (mant_mag > (MANT_CAP - d) / 64'd10) begin
                        raise_error(dss_pkg::ST_RANGE);
                    end else begin
                        mant_mag  = mant_mag * 64'd10 + d;
                        mant_seen = 1'b1;
                        if (scan_phase == SCAN_START)
                            scan_phase = SCAN_BASE;
                        else if (scan_phase == SCAN_FRACTION)
                            frac_count++;
                    end
                end else if (c == dss_pkg::CH_POINT) begin
                    if (scan_phase == SCAN_START || scan_phase == SCAN_BASE)
                        scan_phase = SCAN_FRACTION;
                    else
                        raise_error(dss_pkg::ST_SYNTAX);
                end else if (c == dss_pkg::CH_E_LOW || c == dss_pkg::CH_E_UP) begin
                    if (scan_phase == SCAN_FRACTION)
                        scan_phase = SCAN_EXP;
                    else
                        raise_error(dss_pkg::ST_SYNTAX);
                end else begin
                    raise_error(dss_pkg::ST_SYNTAX);
                end
            end
        end
    endtask

    // ---------------- text building ----------------

    task automatic add_draft(input logic hold);
        t_text_byte t;
        foreach (draft[i]) begin
            t.ch   = draft[i];
            t.hold = hold && (i == 0);
            text_q.push_back(t);
        end
        t.ch   = dss_pkg::CH_NUL;
        t.hold = hold && (draft.size() == 0);
        text_q.push_back(t);
        strings_made++;
    endtask

    task automatic add_text(input string s, input logic hold);
        draft.delete();
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
        add_draft(hold);
    endtask

    task automatic push_digits(input int n, input logic lead_two);
        for (int i = 0; i < n; i++) begin
            if (lead_two && i == 0)
                draft.push_back(dss_pkg::CH_ZERO + 8'd2);
            else
                draft.push_back(dss_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic push_sign();
        case ($urandom_range(0, 2))
            1: draft.push_back(dss_pkg::CH_PLUS);
            2: draft.push_back(dss_pkg::CH_MINUS);
            default: ;
        endcase
    endtask

    task automatic build_number();
        draft.delete();
        push_sign();
        if ($urandom_range(0, 4) == 0)
            push_digits($urandom_range(17, 21), 1'b0);
        else
            push_digits($urandom_range(0, 8), 1'b0);
        if ($urandom_range(0, 3) != 0) begin
            draft.push_back(dss_pkg::CH_POINT);
            push_digits($urandom_range(0, 5) == 0 ? $urandom_range(6, 20)
                                                  : $urandom_range(0, 5), 1'b0);
            if ($urandom_range(0, 1) == 1) begin
                draft.push_back($urandom_range(0, 1) ? dss_pkg::CH_E_UP
                                                     : dss_pkg::CH_E_LOW);
                push_sign();
                if ($urandom_range(0, 3) == 0)
                    push_digits($urandom_range(10, 11), $urandom_range(0, 1) == 1);
                else
                    push_digits($urandom_range(1, 3), 1'b0);
            end
        end
    endtask

    task automatic break_draft();
        logic [7:0] c;
        int         pos;
        case ($urandom_range(0, 5))
            0: c = dss_pkg::CH_PLUS;
            1: c = dss_pkg::CH_MINUS;
            2: c = dss_pkg::CH_POINT;
            3: c = dss_pkg::CH_E_LOW;
            4: c = dss_pkg::CH_E_UP;
            default: c = 8'($urandom_range(1, 255));
        endcase
        pos = $urandom_range(0, draft.size());
        if (pos < draft.size() && $urandom_range(0, 1) == 1)
            draft[pos] = c;
        else
            draft.insert(pos, c);
    endtask

    // ---------------- clock, reset, timeout ----------------

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        clear_split();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout, %0d bytes pending, %0d results outstanding",
                 $time, text_q.size(), split_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------- driver ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left        <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (text_q.size() == 0 ||
                         (text_q[0].hold && split_q.size() != 0)) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                i_s_axis_tdata  <= text_q[0].ch;
                i_s_axis_tvalid <= 1'b1;
                void'(text_q.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern, switches at random among four modes driven by rx_count
    always @(negedge i_clk) begin
        logic ready;
        case (rx_mode)
            0: ready = 1'b1;
            1: ready = 1'($urandom_range(0, 1));
            2: ready = (rx_count % 4 == 0);
            default: ready = rx_count[3];
        endcase
        if (rx_count % 64 == 63)
            rx_mode <= $urandom_range(0, 3);
        rx_count        <= rx_count + 1;
        i_m_axis_tready <= ready;
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        t_split_result want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                status_seen[o_m_axis_tuser]++;
                if (split_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected item, status %0d mantissa %0d exponent %0d",
                             $time, o_m_axis_tuser, $signed(o_m_axis_tdata[63:0]),
                             $signed(o_m_axis_tdata[95:64]));
                end else begin
                    want = split_q.pop_front();
                    if (o_m_axis_tuser !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_m_axis_tuser);
                    end
                    if (o_m_axis_tdata[63:0] !== want.mantissa) begin
                        fail_count++;
                        $display("%0t: mantissa expected %0d actual %0d", $time,
                                 $signed(want.mantissa), $signed(o_m_axis_tdata[63:0]));
                    end
                    if (o_m_axis_tdata[95:64] !== want.exponent) begin
                        fail_count++;
                        $display("%0t: exponent expected %0d actual %0d", $time,
                                 $signed(want.exponent), $signed(o_m_axis_tdata[95:64]));
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                split_char(i_s_axis_tdata);
                bytes_taken++;
                in_taken <= 1'b1;
            end else begin
                in_taken <= 1'b0;
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    // ---------------- stimulus and end of run ----------------

    initial begin
        int made;
        int k;
        int n;
        logic hold;

        // directed strings
        add_text("", 1'b0);
        add_text("0", 1'b0);
        add_text("-9223372036854775808", 1'b0);
        add_text("9223372036854775807", 1'b0);
        add_text("9223372036854775808", 1'b1);
        add_text("-9223372036854775809", 1'b0);
        add_text("+12.5e-3", 1'b0);
        add_text("-.5E+7", 1'b0);
        add_text("1.e5", 1'b0);
        add_text("1.0e2147483648", 1'b0);
        add_text("-1.5e-2147483648", 1'b0);
        add_text("1.0e2147483649", 1'b0);
        add_text(".", 1'b0);
        add_text("+", 1'b0);
        add_text("1e5", 1'b0);
        add_text("1.5e", 1'b0);
        add_text("1.5e+", 1'b0);
        add_text("1.5e3+", 1'b0);
        add_text("1.2.3", 1'b0);
        add_text("1-2", 1'b0);
        add_text("1.5e2.0", 1'b0);
        add_text("12a", 1'b0);
        draft.delete();
        draft.push_back(8'hFF);
        draft.push_back(8'h80);
        add_draft(1'b0);
        draft.delete();
        repeat (63) draft.push_back(dss_pkg::CH_ZERO);
        add_draft(1'b0);
        draft.delete();
        repeat (64) draft.push_back(dss_pkg::CH_ZERO);
        add_draft(1'b0);
        add_text("+-000000000000000000000000000000000000000000000000000000000000000000",
                 1'b0);
        add_text("99999999999999999999000000000000000000000000000000000000000000000000",
                 1'b0);

        // random strings
        made = 0;
        while (made < RANDOM_BYTES) begin
            k    = $urandom_range(0, 99);
            hold = (made == 0) || ($urandom_range(0, 29) == 0);
            if (k < 70) begin
                build_number();
            end else if (k < 85) begin
                build_number();
                break_draft();
                if ($urandom_range(0, 2) == 0)
                    break_draft();
            end else if (k < 95) begin
                draft.delete();
                repeat ($urandom_range(0, 8))
                    draft.push_back(8'($urandom_range(1, 255)));
            end else begin
                draft.delete();
                n = $urandom_range(58, 70);
                repeat (n) draft.push_back(dss_pkg::CH_ZERO);
                if ($urandom_range(0, 1) == 1)
                    draft[$urandom_range(0, n - 1)] = dss_pkg::CH_POINT;
            end
            made += draft.size() + 1;
            add_draft(hold);
        end

        @(posedge i_clk);
        while (!(text_q.size() == 0 && !i_s_axis_tvalid && split_q.size() == 0))
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d strings in %0d bytes under bursty input and stalled output",
                 strings_made, bytes_taken);
        $display("statuses returned: ok %0d, syntax %0d, too long %0d, out of range %0d",
                 status_seen[dss_pkg::ST_OK], status_seen[dss_pkg::ST_SYNTAX],
                 status_seen[dss_pkg::ST_TOO_LONG], status_seen[dss_pkg::ST_RANGE]);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
